[design/differential_drive_odometry_defines.svh]
// Assertion macros for the odometry block
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_DEFINES_SVH
`ifndef ASSERT_OFF
`define DDO_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DDO_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DDO_ASSERT(label, prop, msg)
`define DDO_ASSERT_RST(label, prop, msg)
`endif
`endif

[design/ddo_pkg.sv]
package ddo_pkg;
  localparam int SLOT_COUNT_DEF   = 8;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANGLE_TABLE_LEN  = 24;
  localparam logic [31:0] HPC_RESET = 32'd1048576;
  localparam logic signed [23:0] CORDIC_START = 24'sd39797;

  typedef enum logic [1:0] {
    CMD_MOVE  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_SNAP  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_ITER, ST_ACC, ST_REL, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic iter_init;
    logic iter;
    logic acc;
    logic rel;
  } ctl_t;

  typedef struct packed {
    logic is_move;
    logic iter_last;
  } sts_t;

  function automatic logic [31:0] angle_at(input logic [4:0] i);
    logic [31:0] t;
    begin
      case (i)
        5'd0: t = 32'h20000000;  5'd1: t = 32'h12E4051E;
        5'd2: t = 32'h09FB385B;  5'd3: t = 32'h051111D4;
        5'd4: t = 32'h028B0D43;  5'd5: t = 32'h0145D7E1;
        5'd6: t = 32'h00A2F61E;  5'd7: t = 32'h00517C55;
        5'd8: t = 32'h0028BE53;  5'd9: t = 32'h00145F2F;
        5'd10: t = 32'h000A2F98; 5'd11: t = 32'h000517CC;
        5'd12: t = 32'h00028BE6; 5'd13: t = 32'h000145F3;
        5'd14: t = 32'h0000A2FA; 5'd15: t = 32'h0000517D;
        5'd16: t = 32'h000028BE; 5'd17: t = 32'h0000145F;
        5'd18: t = 32'h00000A30; 5'd19: t = 32'h00000518;
        5'd20: t = 32'h0000028C; 5'd21: t = 32'h00000146;
        5'd22: t = 32'h000000A3; 5'd23: t = 32'h00000051;
        default: t = 32'h0;
      endcase
      return t;
    end
  endfunction
endpackage

[design/ddo_ctrl.sv]
module ddo_ctrl #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          cfg_ready,
  input  ddo_pkg::sts_t sts,
  output ddo_pkg::ctl_t ctl
);
  import ddo_pkg::*;
  `include "differential_drive_odometry_defines.svh"

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    cfg_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cfg_ready = 1'b1;
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        ctl.mul       = 1'b1;
        ctl.iter_init = 1'b1;
        state_nxt     = sts.is_move ? ST_ITER : ST_ACC;
      end
      ST_ITER: begin
        ctl.iter = 1'b1;
        if (sts.iter_last) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        ctl.acc   = 1'b1;
        state_nxt = ST_REL;
      end
      ST_REL: begin
        ctl.rel   = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `DDO_ASSERT(a_out_after_rel, (state_r == ST_REL) |=> out_valid, "result not shown")
  `DDO_ASSERT(a_no_take_busy, out_valid |-> in_stall, "input taken while busy")
  `DDO_ASSERT(a_hold_out, (out_valid && out_stall) |=> out_valid, "result dropped")
  `DDO_ASSERT_RST(a_rst_idle, !rst_n |=> (state_r == ST_IDLE), "reset not idle")
endmodule

[design/ddo_datapath.sv]
module ddo_datapath #(
  parameter int SLOT_COUNT   = ddo_pkg::SLOT_COUNT_DEF,
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ddo_pkg::ctl_t       ctl,
  output ddo_pkg::sts_t       sts,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_data,
  input  logic [1:0]          in_cmd,
  input  logic signed [11:0]  in_right_count,
  input  logic signed [11:0]  in_left_count,
  input  logic [3:0]          in_slot_index,
  output logic signed [14:0]  out_pos_x,
  output logic signed [14:0]  out_pos_y,
  output logic [31:0]         out_heading,
  output logic signed [15:0]  out_rel_x,
  output logic signed [15:0]  out_rel_y,
  output logic [31:0]         out_rel_heading,
  output logic                out_index_error
);
  import ddo_pkg::*;

  localparam int STEPS = (CORDIC_STEPS > ANGLE_TABLE_LEN) ? ANGLE_TABLE_LEN : CORDIC_STEPS;
  localparam int SW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic [31:0]        hpc_r;
  logic [1:0]         cmd_r;
  logic signed [11:0] r_r, l_r;
  logic [3:0]         slot_r;
  logic signed [12:0] dist_r;
  logic signed [44:0] prod_r;
  logic signed [15:0] xd_r, yd_r;
  logic [31:0]        hd_r;
  logic signed [23:0] cx_r, cy_r;
  logic signed [32:0] cz_r;
  logic               neg_r;
  logic [4:0]         it_r;
  logic [14:0]        snx_mem [SLOT_COUNT];
  logic [14:0]        sny_mem [SLOT_COUNT];
  logic [31:0]        snh_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] sv_r;

  logic signed [12:0] diff;
  logic [63:0]        up;
  logic [31:0]        mid, mid_rot;
  logic               qneg;
  logic signed [23:0] sx, sy;
  logic [31:0]        tab;
  logic signed [23:0] cfin, sfin;
  logic signed [36:0] px, py;
  logic signed [37:0] sumx, sumy;
  logic signed [37:0] qx, qy;
  logic               slot_ok;
  logic [SW-1:0]      sidx;
  logic signed [14:0] hx, hy;
  logic [14:0]        ex, ey;
  logic [31:0]        eh;

  assign diff    = 13'(r_r) - 13'(l_r);
  assign up      = 64'(prod_r);
  assign mid     = hd_r + up[32:1];
  assign qneg    = mid[31] ^ mid[30];
  assign mid_rot = qneg ? mid - 32'h80000000 : mid;
  assign sx      = cx_r >>> it_r;
  assign sy      = cy_r >>> it_r;
  assign tab     = angle_at(it_r);
  assign sts.is_move   = (cmd_r == CMD_MOVE);
  assign sts.iter_last = (it_r == 5'(STEPS - 1));
  assign cfin    = neg_r ? -cx_r : cx_r;
  assign sfin    = neg_r ? -cy_r : cy_r;
  assign px      = 37'(dist_r) * 37'(cfin);
  assign py      = 37'(dist_r) * 37'(sfin);
  assign sumx    = 38'($signed({xd_r, 16'h0})) + 38'(px);
  assign sumy    = 38'($signed({yd_r, 16'h0})) + 38'(py);
  assign qx      = (sumx < 0) ? -((-sumx) >>> 16) : (sumx >>> 16);
  assign qy      = (sumy < 0) ? -((-sumy) >>> 16) : (sumy >>> 16);
  assign slot_ok = ({28'd0, slot_r} < 32'(SLOT_COUNT));
  assign sidx    = slot_r[SW-1:0];
  assign hx      = xd_r[15:1];
  assign hy      = yd_r[15:1];
  assign ex      = (sv_r[sidx]) ? snx_mem[sidx] : 15'd0;
  assign ey      = (sv_r[sidx]) ? sny_mem[sidx] : 15'd0;
  assign eh      = (sv_r[sidx]) ? snh_mem[sidx] : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hpc_r <= HPC_RESET;
      xd_r  <= '0;
      yd_r  <= '0;
      hd_r  <= '0;
      sv_r  <= '0;
    end else begin
      if (cfg_we) begin
        hpc_r <= cfg_data;
      end
      if (ctl.acc) begin
        if (cmd_r == CMD_MOVE) begin
          xd_r <= qx[15:0];
          yd_r <= qy[15:0];
          hd_r <= hd_r + up[31:0];
        end else if (cmd_r == CMD_CLEAR) begin
          xd_r <= '0;
          yd_r <= '0;
          hd_r <= '0;
        end
      end
      if (ctl.rel && cmd_r == CMD_SNAP && slot_ok) begin
        sv_r[sidx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r  <= in_cmd;
      r_r    <= in_right_count;
      l_r    <= in_left_count;
      slot_r <= in_slot_index;
    end
    if (ctl.mul) begin
      dist_r <= 13'(r_r) + 13'(l_r);
      prod_r <= 45'(diff) * $signed({13'd0, hpc_r});
    end
    if (ctl.iter_init) begin
      cx_r  <= CORDIC_START;
      cy_r  <= '0;
      it_r  <= '0;
      cz_r  <= '0;
      neg_r <= 1'b0;
    end
    if (ctl.iter) begin
      if (it_r == 5'd0) begin
        neg_r <= qneg;
        cx_r  <= CORDIC_START;
        if (mid_rot[31]) begin
          cz_r <= 33'($signed(mid_rot)) + 33'(tab);
          cy_r <= -CORDIC_START;
        end else begin
          cz_r <= 33'($signed(mid_rot)) - 33'(tab);
          cy_r <= CORDIC_START;
        end
      end else if (!cz_r[32]) begin
        cx_r <= cx_r - sy;
        cy_r <= cy_r + sx;
        cz_r <= cz_r - 33'(tab);
      end else begin
        cx_r <= cx_r + sy;
        cy_r <= cy_r - sx;
        cz_r <= cz_r + 33'(tab);
      end
      it_r <= it_r + 5'd1;
    end
    if (ctl.rel) begin
      out_pos_x   <= hx;
      out_pos_y   <= hy;
      out_heading <= hd_r;
      if (slot_ok) begin
        if (cmd_r == CMD_SNAP) begin
          snx_mem[sidx]   <= hx;
          sny_mem[sidx]   <= hy;
          snh_mem[sidx]   <= hd_r;
          out_rel_x       <= '0;
          out_rel_y       <= '0;
          out_rel_heading <= '0;
        end else begin
          out_rel_x       <= 16'(hx) - 16'($signed(ex));
          out_rel_y       <= 16'(hy) - 16'($signed(ey));
          out_rel_heading <= hd_r - eh;
        end
        out_index_error <= 1'b0;
      end else begin
        out_rel_x       <= '0;
        out_rel_y       <= '0;
        out_rel_heading <= '0;
        out_index_error <= 1'b1;
      end
    end
  end
endmodule

[design/differential_drive_odometry.sv]
// Differential-drive dead-reckoning odometry.
// Input channel (in_valid/in_stall): one request per command - move with
// wheel count deltas, clear origin, or record the pose into a snapshot slot.
// Result channel (out_valid/out_stall): one result per request, with halved
// absolute pose, heading and pose relative to the chosen slot.
// Config channel (cfg_valid/cfg_ready): heading step per count difference,
// taken only while the block is idle.
// A move passes through the MUL, ITER, ACC and REL states from acceptance to
// result, the shared CORDIC unit iterating once per cycle in ITER; clear,
// snapshot and no-op requests skip ITER. One request at a time: no new
// request is accepted until the last result has been taken.
// Reset clears the pose, heading and snapshot slots and restores the step
// register to its default.
// While a result is shown and out_stall is high, the result holds and no request is accepted.
module differential_drive_odometry #(
  parameter int SLOT_COUNT   = ddo_pkg::SLOT_COUNT_DEF,
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic signed [11:0] in_right_count,
  input  logic signed [11:0] in_left_count,
  input  logic [3:0]         in_slot_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [14:0] out_pos_x,
  output logic signed [14:0] out_pos_y,
  output logic [31:0]        out_heading,
  output logic signed [15:0] out_rel_x,
  output logic signed [15:0] out_rel_y,
  output logic [31:0]        out_rel_heading,
  output logic               out_index_error,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);
  import ddo_pkg::*;

  ctl_t ctl;
  sts_t sts;

  ddo_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .cfg_ready, .sts, .ctl
  );

  ddo_datapath #(.SLOT_COUNT(SLOT_COUNT), .CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk, .rst_n, .ctl, .sts,
    .cfg_we(cfg_valid && cfg_ready), .cfg_data,
    .in_cmd, .in_right_count, .in_left_count, .in_slot_index,
    .out_pos_x, .out_pos_y, .out_heading, .out_rel_x, .out_rel_y,
    .out_rel_heading, .out_index_error
  );
endmodule
